[rtl/core/csmp_pkg.sv]
`timescale 1ns / 1ps

package csmp_pkg;

    // Result field widths
    localparam int IDX_W = 6;
    localparam int VAL_W = 30;

    // Table size follows the highest index
    localparam int MAX_INDEX = 63;
    localparam int TBL_DEPTH = MAX_INDEX + 1;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_INDEX);

    // Shared multiplier: 33 x 33 bits into a 66-bit product
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;

    // Modulus and reduction constants
    localparam logic [VAL_W-1:0] CAT_PRIME  = 30'd1000000007;
    // 2^33 mod prime, folds the upper bits back below 2^33 weight
    localparam logic [VAL_W-1:0] FOLD_C     = 30'd589934536;
    // floor(2^62 / prime), Barrett reciprocal
    localparam logic [OP_W-1:0]  BARRETT_MU = 33'd4611685986;
    // Multiples of the prime for the final correction
    localparam logic [31:0] PRIME_X1 = 32'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;
    localparam logic [31:0] PRIME_X3 = 32'd3000000021;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MAC,
        ST_MDRAIN,
        ST_F1_MUL,
        ST_F1_ADD,
        ST_F2_MUL,
        ST_F2_ADD,
        ST_B_MUL1,
        ST_B_MUL2,
        ST_B_FIX,
        ST_EMIT,
        ST_DRAIN
    } t_state;

endpackage

[rtl/core/catalan_sequence_mod_prime_unit.sv]
`timescale 1ns / 1ps

// Catalan numbers 0..n modulo 1000000007.
// Input channel: i_count is taken at a rising edge with start high and busy
// low. Counts above the table size saturate to the largest index.
// Result channel: one item per index 0..n, in order, on o_index, o_value and
// o_last, each shown for exactly one cycle with o_strobe high. o_last marks
// index n. The receiver cannot stall; results are never held back.
// busy stays high from the accept until the last result has been shown.
// Datapath: one 33x33 multiplier is shared by the multiply-accumulate loop and
// the modular reduction. Row i sums ceil(i/2) products (symmetric product
// pairs are doubled), then drains the MAC pipeline and runs the reduction
// steps (two folds, two Barrett multiplies, one correction). The first
// result appears after the whole table is built, then one result per cycle.
// One item is in work at a time.
// Reset: synchronous active-low reset returns the sequencer to idle and drops
// any result in flight. The table needs no clearing: every entry read for an
// item is written earlier for the same item.
module catalan_sequence_mod_prime_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [csmp_pkg::IDX_W-1:0]  i_count,
    output logic                        o_strobe,
    output logic [csmp_pkg::IDX_W-1:0]  o_index,
    output logic [csmp_pkg::VAL_W-1:0]  o_value,
    output logic                        o_last
);

    import csmp_pkg::*;

    t_state r_state;
    t_state n_state;

    // Row, column, request and emit counters
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_k, n_k;

    // Accumulator and product
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0] r_prod, n_prod;

    // MAC pipeline: read data stage, product stage
    logic r_v1, n_v1;
    logic r_v2, n_v2;
    logic r_mid1, n_mid1;
    logic r_dbl2, n_dbl2;

    // Result registers
    logic             r_ov, n_ov;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic             r_olast, n_olast;

    // Shared multiplier operands
    logic [OP_W-1:0] mul_a;
    logic [OP_W-1:0] mul_b;

    // Table port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr_a;
    logic [IDX_W-1:0] ram_raddr_b;
    logic [VAL_W-1:0] ram_rd_a;
    logic [VAL_W-1:0] ram_rd_b;

    logic [IDX_W-1:0] j_max;
    logic [IDX_W-1:0] partner;
    logic [31:0]      fix_raw;
    logic [VAL_W-1:0] fix_val;

    csmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    // Column bound and mirrored column for the current row
    assign j_max   = (r_i - IDX_W'(1)) >> 1;
    assign partner = r_i - IDX_W'(1) - r_j;

    // Correct the Barrett remainder, which lies below four times the prime
    assign fix_raw = r_acc[31:0] - r_prod[31:0];
    always_comb begin
        if (fix_raw >= PRIME_X3) begin
            fix_val = VAL_W'(fix_raw - PRIME_X3);
        end else if (fix_raw >= PRIME_X2) begin
            fix_val = VAL_W'(fix_raw - PRIME_X2);
        end else if (fix_raw >= PRIME_X1) begin
            fix_val = VAL_W'(fix_raw - PRIME_X1);
        end else begin
            fix_val = VAL_W'(fix_raw);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = (r_n == '0) ? ST_EMIT : ST_MAC;
            end
            ST_MAC: begin
                if (r_j == j_max) begin
                    n_state = ST_MDRAIN;
                end
            end
            ST_MDRAIN: begin
                if (!r_v1) begin
                    n_state = ST_F1_MUL;
                end
            end
            ST_F1_MUL: n_state = ST_F1_ADD;
            ST_F1_ADD: n_state = ST_F2_MUL;
            ST_F2_MUL: n_state = ST_F2_ADD;
            ST_F2_ADD: n_state = ST_B_MUL1;
            ST_B_MUL1: n_state = ST_B_MUL2;
            ST_B_MUL2: n_state = ST_B_FIX;
            ST_B_FIX: begin
                n_state = (r_i == r_n) ? ST_EMIT : ST_MAC;
            end
            ST_EMIT: begin
                if (r_k == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, table port, multiplier operands
    always_comb begin
        busy        = (r_state != ST_IDLE);
        ram_we      = 1'b0;
        ram_waddr   = r_i;
        ram_wdata   = fix_val;
        ram_raddr_a = r_j;
        ram_raddr_b = partner;
        mul_a       = '0;
        mul_b       = '0;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = VAL_W'(1);
            end
            ST_MAC, ST_MDRAIN: begin
                mul_a = OP_W'(ram_rd_a);
                mul_b = OP_W'(ram_rd_b);
            end
            ST_F1_MUL, ST_F2_MUL: begin
                mul_a = r_acc[PROD_W-1:OP_W];
                mul_b = OP_W'(FOLD_C);
            end
            ST_B_MUL1: begin
                mul_a = OP_W'(r_acc[61:30]);
                mul_b = BARRETT_MU;
            end
            ST_B_MUL2: begin
                mul_a = r_prod[64:32];
                mul_b = OP_W'(CAT_PRIME);
            end
            ST_B_FIX: begin
                ram_we = 1'b1;
            end
            ST_EMIT: begin
                ram_raddr_a = r_k;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_k     = r_k;
        n_acc   = r_acc;
        n_prod  = {{OP_W{1'b0}}, mul_a} * {{OP_W{1'b0}}, mul_b};
        n_v1    = (r_state == ST_MAC);
        n_mid1  = (r_j == partner);
        n_v2    = r_v1;
        n_dbl2  = !r_mid1;
        n_ov    = (r_state == ST_EMIT);
        n_oidx  = r_k;
        n_olast = (r_k == r_n);

        // Fold the product into the row sum; mirrored pairs count twice
        if (r_v2) begin
            n_acc = r_acc + (r_dbl2 ? (r_prod << 1) : r_prod);
        end

        case (r_state)
            ST_IDLE: begin
                n_n = (i_count > MAX_IDX) ? MAX_IDX : i_count;
            end
            ST_INIT: begin
                n_i   = IDX_W'(1);
                n_j   = '0;
                n_k   = '0;
                n_acc = '0;
            end
            ST_MAC: begin
                n_j = r_j + IDX_W'(1);
            end
            ST_F1_ADD, ST_F2_ADD: begin
                n_acc = r_prod + {{(PROD_W-OP_W){1'b0}}, r_acc[OP_W-1:0]};
            end
            ST_B_FIX: begin
                n_i   = r_i + IDX_W'(1);
                n_j   = '0;
                n_k   = '0;
                n_acc = '0;
            end
            ST_EMIT: begin
                n_k = r_k + IDX_W'(1);
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_n     <= n_n;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_mid1  <= n_mid1;
        r_dbl2  <= n_dbl2;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    assign o_strobe = r_ov;
    assign o_index  = r_oidx;
    assign o_value  = ram_rd_a;
    assign o_last   = r_olast;

`ifndef SYNTHESIS
    // Results only appear while an item is in work
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a busy period");

    // An accepted item raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // Results of one item come back to back with rising index
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=>
            (o_strobe && (o_index == IDX_W'($past(o_index) + IDX_W'(1)))))
        else $error("result index did not advance");

    // The burst of results starts at index zero
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_index == '0))
        else $error("first result index not zero");

    // Nothing follows the last result
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result after last");
`endif

endmodule

[rtl/core/csmp_ram.sv]
`timescale 1ns / 1ps

module csmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write one entry, read two with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule
